FILE: src/pgmd_pkg.sv
package pgmd_pkg;

    // error codes carried in a result item
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_MAGIC  = 3'd1;
    localparam logic [2:0] ERR_TOKEN  = 3'd2;
    localparam logic [2:0] ERR_SIZE   = 3'd3;
    localparam logic [2:0] ERR_MAXVAL = 3'd4;
    localparam logic [2:0] ERR_PIXEL  = 3'd5;
    localparam logic [2:0] ERR_EARLY  = 3'd6;

    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_2    = 8'h32;
    localparam logic [7:0] CHAR_5    = 8'h35;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;

    localparam logic [16:0] ACC_SAT = 17'd65536;

    localparam int TDATA_OUT_W = 72;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic [15:0] column;
        logic [15:0] row;
        logic        wide_samples;
        logic [15:0] max_level;
        logic        last_pixel;
        logic [2:0]  error_code;
    } result_t;

endpackage

FILE: src/pgmd_parser.sv
module pgmd_parser
    import pgmd_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 65535
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [2:0] {
        PH_MAGIC_P,
        PH_MAGIC_D,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_RASTER,
        PH_DONE,
        PH_HALT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        ascii_mode_reg, ascii_mode_next;
    logic [15:0] image_width_reg, image_width_next;
    logic [15:0] image_height_reg, image_height_next;
    logic [15:0] max_level_reg, max_level_next;
    logic [16:0] accum_reg, accum_next;
    logic        digit_seen_reg, digit_seen_next;
    logic        in_comment_reg, in_comment_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic        low_pending_reg, low_pending_next;
    logic [15:0] column_reg, column_next;
    logic [15:0] row_reg, row_next;

    logic        is_ws, is_digit, is_eol;
    logic [19:0] acc_sum;
    logic [16:0] acc_sat;
    logic [16:0] col_inc, row_inc;
    logic        col_end, is_last;
    logic        emit_pix, emit_err;
    logic [16:0] pix_val;
    logic [2:0]  err_code;

    assign is_ws    = (data_byte == 8'h20) || (data_byte inside {[8'h09:8'h0D]});
    assign is_digit = data_byte inside {[8'h30:8'h39]};
    assign is_eol   = (data_byte == CHAR_LF) || (data_byte == CHAR_CR);

    // decimal accumulate, saturating just past 16 bits
    assign acc_sum = {3'b000, accum_reg} * 20'd10 + {16'd0, data_byte[3:0]};
    assign acc_sat = (acc_sum > {3'b000, ACC_SAT}) ? ACC_SAT : acc_sum[16:0];

    assign col_inc = {1'b0, column_reg} + 17'd1;
    assign row_inc = {1'b0, row_reg} + 17'd1;
    assign col_end = col_inc >= {1'b0, image_width_reg};
    assign is_last = col_end && (row_inc >= {1'b0, image_height_reg});

    always_comb begin
        phase_next        = phase_reg;
        ascii_mode_next   = ascii_mode_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        max_level_next    = max_level_reg;
        accum_next        = accum_reg;
        digit_seen_next   = digit_seen_reg;
        in_comment_next   = in_comment_reg;
        high_byte_next    = high_byte_reg;
        low_pending_next  = low_pending_reg;
        column_next       = column_reg;
        row_next          = row_reg;
        emit_pix          = 1'b0;
        emit_err          = 1'b0;
        pix_val           = 17'd0;
        err_code          = ERR_NONE;

        if (end_of_stream) begin
            if (phase_reg == PH_MAGIC_P || phase_reg == PH_DONE || phase_reg == PH_HALT) begin
                emit_pix = 1'b0;
            end else if (phase_reg == PH_RASTER && ascii_mode_reg && digit_seen_reg
                         && is_last) begin
                emit_pix = 1'b1;
                pix_val  = accum_reg;
            end else begin
                emit_err = 1'b1;
                err_code = ERR_EARLY;
            end
        end else begin
            case (phase_reg)
                PH_MAGIC_P: begin
                    if (data_byte == CHAR_P) begin
                        phase_next = PH_MAGIC_D;
                    end else begin
                        emit_err = 1'b1;
                        err_code = ERR_MAGIC;
                    end
                end
                PH_MAGIC_D: begin
                    if (data_byte == CHAR_2) begin
                        ascii_mode_next = 1'b1;
                        phase_next      = PH_WIDTH;
                    end else if (data_byte == CHAR_5) begin
                        ascii_mode_next = 1'b0;
                        phase_next      = PH_WIDTH;
                    end else begin
                        emit_err = 1'b1;
                        err_code = ERR_MAGIC;
                    end
                end
                PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                    if (in_comment_reg) begin
                        if (is_eol) begin
                            in_comment_next = 1'b0;
                        end
                    end else if (is_digit) begin
                        accum_next      = acc_sat;
                        digit_seen_next = 1'b1;
                    end else if (is_ws || data_byte == CHAR_HASH) begin
                        if (data_byte == CHAR_HASH) begin
                            in_comment_next = 1'b1;
                        end
                        if (digit_seen_reg) begin
                            accum_next      = 17'd0;
                            digit_seen_next = 1'b0;
                            if (phase_reg == PH_MAXVAL) begin
                                if (accum_reg == 17'd0 || accum_reg[16]) begin
                                    emit_err = 1'b1;
                                    err_code = ERR_MAXVAL;
                                end else begin
                                    max_level_next   = accum_reg[15:0];
                                    phase_next       = PH_RASTER;
                                    column_next      = 16'd0;
                                    row_next         = 16'd0;
                                    low_pending_next = 1'b0;
                                end
                            end else if (accum_reg == 17'd0 || accum_reg[16]
                                         || accum_reg > 17'(MAX_DIMENSION)) begin
                                emit_err = 1'b1;
                                err_code = ERR_SIZE;
                            end else if (phase_reg == PH_WIDTH) begin
                                image_width_next = accum_reg[15:0];
                                phase_next       = PH_HEIGHT;
                            end else begin
                                image_height_next = accum_reg[15:0];
                                phase_next        = PH_MAXVAL;
                            end
                        end
                    end else begin
                        emit_err = 1'b1;
                        err_code = ERR_TOKEN;
                    end
                end
                PH_RASTER: begin
                    if (in_comment_reg) begin
                        if (is_eol) begin
                            in_comment_next = 1'b0;
                        end
                    end else if (!ascii_mode_reg) begin
                        if (max_level_reg[15:8] == 8'd0) begin
                            emit_pix = 1'b1;
                            pix_val  = {9'd0, data_byte};
                        end else if (!low_pending_reg) begin
                            high_byte_next   = data_byte;
                            low_pending_next = 1'b1;
                        end else begin
                            low_pending_next = 1'b0;
                            emit_pix         = 1'b1;
                            pix_val          = {1'b0, high_byte_reg, data_byte};
                        end
                    end else if (is_digit) begin
                        accum_next      = acc_sat;
                        digit_seen_next = 1'b1;
                    end else if (is_ws) begin
                        if (digit_seen_reg) begin
                            accum_next      = 17'd0;
                            digit_seen_next = 1'b0;
                            emit_pix        = 1'b1;
                            pix_val         = accum_reg;
                        end
                    end else begin
                        emit_err = 1'b1;
                        err_code = ERR_PIXEL;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (emit_pix) begin
            if (is_last) begin
                phase_next = PH_DONE;
            end else if (col_end) begin
                column_next = 16'd0;
                row_next    = row_inc[15:0];
            end else begin
                column_next = col_inc[15:0];
            end
        end
        if (emit_err) begin
            phase_next = PH_HALT;
        end

        // end of stream rearms for the next file
        if (end_of_stream) begin
            phase_next        = PH_MAGIC_P;
            ascii_mode_next   = 1'b0;
            image_width_next  = 16'd0;
            image_height_next = 16'd0;
            max_level_next    = 16'd0;
            accum_next        = 17'd0;
            digit_seen_next   = 1'b0;
            in_comment_next   = 1'b0;
            high_byte_next    = 8'd0;
            low_pending_next  = 1'b0;
            column_next       = 16'd0;
            row_next          = 16'd0;
        end
    end

    always_comb begin
        res_valid = emit_pix || emit_err;
        res       = '0;
        if (emit_err) begin
            res.error_code = err_code;
        end else begin
            res.pixel_value  = pix_val[16] ? 16'hFFFF : pix_val[15:0];
            res.column       = column_reg;
            res.row          = row_reg;
            res.wide_samples = |max_level_reg[15:8];
            res.max_level    = max_level_reg;
            res.last_pixel   = is_last;
            res.error_code   = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_MAGIC_P;
            ascii_mode_reg   <= 1'b0;
            image_width_reg  <= 16'd0;
            image_height_reg <= 16'd0;
            max_level_reg    <= 16'd0;
            accum_reg        <= 17'd0;
            digit_seen_reg   <= 1'b0;
            in_comment_reg   <= 1'b0;
            high_byte_reg    <= 8'd0;
            low_pending_reg  <= 1'b0;
            column_reg       <= 16'd0;
            row_reg          <= 16'd0;
        end else if (step) begin
            phase_reg        <= phase_next;
            ascii_mode_reg   <= ascii_mode_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            max_level_reg    <= max_level_next;
            accum_reg        <= accum_next;
            digit_seen_reg   <= digit_seen_next;
            in_comment_reg   <= in_comment_next;
            high_byte_reg    <= high_byte_next;
            low_pending_reg  <= low_pending_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
        end
    end

endmodule

FILE: src/pgm_stream_decoder.sv
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | tdata: data_byte; tlast: end_of_stream
// m_       | out | m_tvalid/m_tready  | tdata: pixel_value, column, row, wide_samples,
//          |     |                    |        max_level, error_code; tlast: last_pixel
//
// one item per cycle sustained while the m_ side takes results; an accepted item passes from the
// input register through the parser logic into the result register
// the header/raster parser state updates once per item, which sets the one-cycle rate
// aresetn is synchronous and clears the parser, input and result valid bits
// a stalled m_ side holds the result; the input register keeps taking items
// until it is full and the result register cannot drain
module pgm_stream_decoder
    import pgmd_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 65535
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // end_of_stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] pixel_value, [31:16] column, [47:32] row, [48] wide_samples,
    // [64:49] max_level, [67:65] error_code, [71:68] zero
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast    // last_pixel
);

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    logic       out_vld_reg;
    result_t    out_res_reg;
    logic       advance;
    logic       res_valid;
    result_t    res;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    pgmd_parser #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= res_valid;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_res_reg.last_pixel;
    assign m_tdata  = {4'd0, out_res_reg.error_code, out_res_reg.max_level,
                       out_res_reg.wide_samples, out_res_reg.row,
                       out_res_reg.column, out_res_reg.pixel_value};

    // an error item carries nothing but its code
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_res_reg.error_code != ERR_NONE |->
            !out_res_reg.last_pixel && out_res_reg.pixel_value == 16'd0
            && out_res_reg.max_level == 16'd0)
        else $error("error item with pixel payload");

    // the input side only stalls when both registers are full and the sink stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_vld_reg && out_vld_reg && !m_tready)
        else $error("input stalled without back pressure");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> out_res_reg.error_code <= ERR_EARLY)
        else $error("undefined error code");

endmodule

FILE: sim/pgm_stream_decoder_checker.sv
module pgm_stream_decoder_checker
    import pgmd_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 65535
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   m_tlast,
    output int                     mismatches,
    output int                     outstanding
);

    typedef enum logic [3:0] {
        ST_WANT_P,
        ST_WANT_DIGIT,
        ST_WIDTH,
        ST_HEIGHT,
        ST_MAXVAL,
        ST_RASTER,
        ST_DONE,
        ST_HALT
    } parse_state_e;

    parse_state_e st;
    logic         ascii;
    logic [15:0]  img_w;
    logic [15:0]  img_h;
    logic [15:0]  maxval;
    logic [16:0]  acc;
    logic         have_digit;
    logic         comment;
    logic [7:0]   hi_byte;
    logic         hi_pending;
    logic [15:0]  col;
    logic [15:0]  row;

    result_t expected_pixels[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic logic is_space(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic at_last_pixel();
        return (int'(col) + 1 >= int'(img_w)) && (int'(row) + 1 >= int'(img_h));
    endfunction

    task automatic clear_state();
        st         = ST_WANT_P;
        ascii      = 1'b0;
        img_w      = '0;
        img_h      = '0;
        maxval     = '0;
        acc        = '0;
        have_digit = 1'b0;
        comment    = 1'b0;
        hi_byte    = '0;
        hi_pending = 1'b0;
        col        = '0;
        row        = '0;
    endtask

    task automatic add_digit(input logic [7:0] b);
        int v;
        v = int'(acc) * 10 + int'(b) - 48;
        acc = (v > 65536) ? ACC_SAT : v[16:0];
        have_digit = 1'b1;
    endtask

    task automatic push_error(input logic [2:0] code);
        result_t r;
        r = '0;
        r.error_code = code;
        expected_pixels.push_back(r);
        st = ST_HALT;
    endtask

    task automatic push_pixel(input int value);
        result_t r;
        logic    last;
        last           = at_last_pixel();
        r.pixel_value  = (value > 65535) ? 16'hFFFF : value[15:0];
        r.column       = col;
        r.row          = row;
        r.wide_samples = (maxval >= 16'd256);
        r.max_level    = maxval;
        r.last_pixel   = last;
        r.error_code   = ERR_NONE;
        expected_pixels.push_back(r);
        if (last) begin
            st = ST_DONE;
        end else if (int'(col) + 1 >= int'(img_w)) begin
            col = '0;
            row = row + 16'd1;
        end else begin
            col = col + 16'd1;
        end
    endtask

    // closes a header number; code stays ERR_NONE when the value is usable
    task automatic end_token(output logic [2:0] code);
        int v;
        v          = int'(acc);
        acc        = '0;
        have_digit = 1'b0;
        code       = ERR_NONE;
        if (st == ST_WIDTH || st == ST_HEIGHT) begin
            if (v == 0 || v > int'(MAX_DIMENSION) || v > 65535) begin
                code = ERR_SIZE;
            end else if (st == ST_WIDTH) begin
                img_w = v[15:0];
                st    = ST_HEIGHT;
            end else begin
                img_h = v[15:0];
                st    = ST_MAXVAL;
            end
        end else if (v == 0 || v > 65535) begin
            code = ERR_MAXVAL;
        end else begin
            maxval     = v[15:0];
            st         = ST_RASTER;
            col        = '0;
            row        = '0;
            hi_pending = 1'b0;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eos);
        logic [2:0] code;
        int         v;
        if (eos) begin
            if (st == ST_WANT_P || st == ST_DONE || st == ST_HALT) begin
                // nothing pending, nothing to report
            end else if (st == ST_RASTER && ascii && have_digit && at_last_pixel()) begin
                push_pixel(int'(acc));
            end else begin
                push_error(ERR_EARLY);
            end
            clear_state();
        end else begin
            case (st)
                ST_WANT_P: begin
                    if (b == CHAR_P) st = ST_WANT_DIGIT;
                    else push_error(ERR_MAGIC);
                end
                ST_WANT_DIGIT: begin
                    if (b == CHAR_2) begin
                        ascii = 1'b1;
                        st    = ST_WIDTH;
                    end else if (b == CHAR_5) begin
                        ascii = 1'b0;
                        st    = ST_WIDTH;
                    end else begin
                        push_error(ERR_MAGIC);
                    end
                end
                ST_WIDTH, ST_HEIGHT, ST_MAXVAL: begin
                    if (comment) begin
                        if (b == CHAR_LF || b == CHAR_CR) comment = 1'b0;
                    end else if (is_digit(b)) begin
                        add_digit(b);
                    end else if (is_space(b) || b == CHAR_HASH) begin
                        code = ERR_NONE;
                        if (have_digit) end_token(code);
                        if (code != ERR_NONE) push_error(code);
                        else if (b == CHAR_HASH) comment = 1'b1;
                    end else begin
                        push_error(ERR_TOKEN);
                    end
                end
                ST_RASTER: begin
                    if (comment) begin
                        if (b == CHAR_LF || b == CHAR_CR) comment = 1'b0;
                    end else if (!ascii) begin
                        if (maxval < 16'd256) begin
                            push_pixel(int'(b));
                        end else if (!hi_pending) begin
                            hi_byte    = b;
                            hi_pending = 1'b1;
                        end else begin
                            hi_pending = 1'b0;
                            push_pixel(int'({hi_byte, b}));
                        end
                    end else if (is_digit(b)) begin
                        add_digit(b);
                    end else if (is_space(b)) begin
                        if (have_digit) begin
                            v          = int'(acc);
                            acc        = '0;
                            have_digit = 1'b0;
                            push_pixel(v);
                        end
                    end else begin
                        push_error(ERR_PIXEL);
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatches++;
        end
    endtask

    task automatic check_result();
        result_t r;
        if (expected_pixels.size() == 0) begin
            $error("result item with nothing expected: tdata %h tlast %b", m_tdata, m_tlast);
            mismatches++;
        end else begin
            r = expected_pixels.pop_front();
            check_field("pixel_value", r.pixel_value, m_tdata[15:0]);
            check_field("column", r.column, m_tdata[31:16]);
            check_field("row", r.row, m_tdata[47:32]);
            check_field("wide_samples", r.wide_samples, m_tdata[48]);
            check_field("max_level", r.max_level, m_tdata[64:49]);
            check_field("error_code", r.error_code, m_tdata[67:65]);
            check_field("last_pixel", r.last_pixel, m_tlast);
        end
    endtask

    // results are compared before the new byte is parsed
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            expected_pixels.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
        end
        outstanding = expected_pixels.size();
    end

endmodule

FILE: sim/pgm_stream_decoder_tb.sv
module pgm_stream_decoder_tb;
    import pgmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int ITEMS_PER_PHASE = 400;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;

    int mismatches;
    int outstanding;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int idle_cycles    = 0;

    logic [7:0] file_q[$];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    pgm_stream_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    pgm_stream_decoder_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic drive_item(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_file();
        foreach (file_q[i]) drive_item(file_q[i], 1'b0);
        drive_item(8'($urandom_range(255)), 1'b1);
        file_q.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
    endtask

    task automatic put_number(input int unsigned v);
        if ($urandom_range(7) == 0) file_q.push_back(8'h30);
        put_text($sformatf("%0d", v));
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(5))
            0: return 8'h20;
            1: return 8'h09;
            2: return CHAR_LF;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return CHAR_CR;
        endcase
    endfunction

    // comment body may hold any byte except the two line ends
    task automatic put_comment();
        logic [7:0] c;
        int         n;
        n = $urandom_range(0, 6);
        file_q.push_back(CHAR_HASH);
        for (int i = 0; i < n; i++) begin
            do c = 8'($urandom_range(255)); while (c == CHAR_LF || c == CHAR_CR);
            file_q.push_back(c);
        end
        file_q.push_back($urandom_range(1) ? CHAR_LF : CHAR_CR);
    endtask

    task automatic put_gap(input logic allow_comment);
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) file_q.push_back(pick_space());
        if (allow_comment && $urandom_range(4) == 0) put_comment();
    endtask

    function automatic int unsigned pick_maxval();
        case ($urandom_range(5))
            0: return 1;
            1: return 255;
            2: return 256;
            3: return 65535;
            4: return $urandom_range(1, 255);
            default: return $urandom_range(256, 65535);
        endcase
    endfunction

    task automatic build_image(input logic ascii, input int unsigned w, input int unsigned h,
                               input int unsigned maxv);
        int unsigned v;
        logic        open_end;
        open_end = 1'b0;
        put_text(ascii ? "P2" : "P5");
        if ($urandom_range(3) != 0) put_gap(1'b1);
        put_number(w);
        put_gap(1'b1);
        put_number(h);
        put_gap(1'b1);
        put_number(maxv);
        // exactly one byte or a whole comment ends maxval, so binary data starts in place
        if ($urandom_range(3) == 0) put_comment();
        else file_q.push_back(pick_space());
        for (int i = 0; i < int'(w * h); i++) begin
            if (ascii) begin
                v = ($urandom_range(19) == 0) ? $urandom_range(0, 99999) : $urandom_range(0, maxv);
                put_number(v);
                if (i == int'(w * h) - 1 && $urandom_range(1) == 0) open_end = 1'b1;
                else put_gap(1'b0);
            end else begin
                file_q.push_back(8'($urandom_range(255)));
                if (maxv >= 256) file_q.push_back(8'($urandom_range(255)));
            end
        end
        if (!open_end && $urandom_range(4) == 0) begin
            for (int i = 0; i < int'($urandom_range(1, 4)); i++)
                file_q.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic random_file(inout int count);
        int idx;
        int n;
        build_image(1'($urandom_range(1)), $urandom_range(1, 6), $urandom_range(1, 6),
                    pick_maxval());
        case ($urandom_range(9))
            0: begin
                idx = $urandom_range(0, file_q.size() - 1);
                file_q[idx] = 8'($urandom_range(255));
            end
            1: begin
                idx = $urandom_range(0, file_q.size() - 1);
                while (file_q.size() > idx) void'(file_q.pop_back());
            end
            2: begin
                file_q.delete();
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    file_q.push_back(($urandom_range(3) == 0) ? CHAR_P : 8'($urandom_range(255)));
            end
            default: ;
        endcase
        count += file_q.size() + 1;
        send_file();
    endtask

    initial begin
        int phase_items;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // end of stream with nothing before it
        send_file();
        put_text("QP5 1 1 255 x");
        send_file();
        put_text("P7");
        send_file();
        put_text("P");
        send_file();
        put_text("P2 3x");
        send_file();
        put_text("P5 0 ");
        send_file();
        put_text("P5 1 65536 ");
        send_file();
        put_text("P2 1 1 999999999 ");
        send_file();
        put_text("P5 1 1 0 ");
        send_file();
        // comments closed by cr and lf, vt as separator, trailing byte ignored
        put_text("P5#c");
        file_q.push_back(CHAR_CR);
        put_text("1");
        file_q.push_back(8'h09);
        put_text("1");
        file_q.push_back(8'h0B);
        put_text("255#z");
        file_q.push_back(CHAR_LF);
        file_q.push_back(8'hFF);
        file_q.push_back(8'h00);
        send_file();
        // width right after the magic digit, two-byte samples
        put_text("P51 2 65535");
        file_q.push_back(CHAR_LF);
        file_q.push_back(8'hFF);
        file_q.push_back(8'hFF);
        file_q.push_back(8'h00);
        file_q.push_back(8'h01);
        send_file();
        // saturating samples, final sample closed by end of stream
        put_text("P2");
        file_q.push_back(8'h0C);
        put_text("2 2 65535 99999 70000 0");
        file_q.push_back(CHAR_CR);
        put_text("65535");
        send_file();
        put_text("P2 1 2 9 3 #");
        send_file();
        put_text("P2 1 1 9 a");
        send_file();
        put_text("P2 2 1 9 5 ");
        send_file();
        put_text("P5 1 1 256 ");
        file_q.push_back(8'hAB);
        send_file();
        put_text("P5 1 1 255 ");
        send_file();
        put_text("P2 1 1 1 7");
        send_file();
        // widest row and tallest column, each cut short after a few samples
        put_text("P5 65535 1 255 ");
        for (int i = 0; i < 8; i++) file_q.push_back(8'($urandom_range(255)));
        send_file();
        put_text("P5 1 65535 255 ");
        for (int i = 0; i < 8; i++) file_q.push_back(8'($urandom_range(255)));
        send_file();
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
                default: begin src_idle_pct = 27; sink_stall_pct = 27; end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) random_file(phase_items);
            wait_drained();
        end

        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
